// ----- rtl/core/ncdf_pkg.sv -----
// Shared types, fixed-point constants and pipeline timing for the normal CDF unit.
// Used by ncdf_div and normal_cdf_unit; depends on nothing else.
package ncdf_pkg;

  localparam int Z_FRAC_BITS   = 14;
  localparam int OUT_FRAC_BITS = 24;
  localparam int Z_W           = 20;
  localparam int OUT_W         = OUT_FRAC_BITS + 1;
  localparam int MAG_W         = 20;

  // Internal values are Q32; operands of the dividers stay below 64.0.
  localparam int QFRAC = 32;
  localparam int QW    = 38;
  localparam int QB    = 36;
  localparam int YW    = 39;

  typedef logic [QW-1:0] opnd_t;
  typedef logic [QB-1:0] quot_t;

  localparam int ZQ_SH = QFRAC - Z_FRAC_BITS;
  localparam int Y_SH  = 2 * ZQ_SH - QFRAC - 1;

  localparam logic [QFRAC:0] QONE  = (QFRAC+1)'(1) << QFRAC;
  localparam logic [QFRAC:0] QHALF = (QFRAC+1)'(1) << (QFRAC - 1);

  // Range tests on the raw magnitude: |z| > 12.7 and |z| <= 1.28.
  localparam int LIM_W   = 28;
  localparam int FAR_NUM = 127;
  localparam int FAR_DEN = 10;
  localparam int CEN_NUM = 128;
  localparam int CEN_DEN = 100;
  localparam logic [LIM_W-1:0] FAR_LIM = LIM_W'(FAR_NUM << Z_FRAC_BITS);
  localparam logic [LIM_W-1:0] CEN_LIM = LIM_W'(CEN_NUM << Z_FRAC_BITS);

  // exp(-y) by range reduction on ln2 and a nested series
  localparam logic [QFRAC-1:0] LN2 = 32'hB17217F8;
  localparam int LN_STEPS  = 7;
  localparam int EXP_TERMS = 12;
  localparam int RECIP_SH  = 36;

  // Output rounding
  localparam int RND_SH = QFRAC - OUT_FRAC_BITS;
  localparam logic [QFRAC+1:0] RND_HALF = (QFRAC+2)'(1) << (RND_SH - 1);
  localparam logic [OUT_W-1:0] OUT_ONE  = OUT_W'(1) << OUT_FRAC_BITS;

  // Coefficients, floor(c * 2^32)
  localparam logic [95:0] DEC_SCALE = 96'd1000000000000;
  localparam opnd_t K_CA = QW'((96'd48695993069200 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_CB = QW'((96'd5928857244380 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_CC = QW'((96'd2624331216790 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_CD = QW'((96'd29821355780800 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_CE = QW'((96'd5758854804580 << QFRAC) / DEC_SCALE);
  localparam logic [QFRAC-1:0] K_CF = QFRAC'((96'd399903438505 << QFRAC) / DEC_SCALE);
  localparam logic [QFRAC-1:0] K_CG = QFRAC'((96'd398942280444 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T1  = QW'((96'd30789933034000 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T2  = QW'((96'd3990194170110 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T3  = QW'((96'd742380924027 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T4  = QW'((96'd15150897245100 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T5  = QW'((96'd4838591280800 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T6  = QW'((96'd5293303249260 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T7  = QW'((96'd151679116635 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T8  = QW'((96'd1986153813640 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T9  = QW'((96'd398064794 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T10 = QW'((96'd1000006153020 << QFRAC) / DEC_SCALE);
  localparam opnd_t K_T11 = QW'((96'd38052 << QFRAC) / DEC_SCALE);
  localparam logic [QFRAC-1:0] K_T12 = QFRAC'((96'd398942280385 << QFRAC) / DEC_SCALE);

  // Pipeline timing, in stages after the input register
  localparam int DIV_LAT   = QB + 1;
  localparam int T1_IN     = 0;
  localparam int T2_IN     = T1_IN + DIV_LAT;
  localparam int T3_REG    = T2_IN + DIV_LAT;
  localparam int T3_IN     = T3_REG + 1;
  localparam int T4_REG    = T3_IN + DIV_LAT;
  localparam int T4_IN     = T4_REG + 1;
  localparam int T5_IN     = T4_IN + DIV_LAT;
  localparam int T6_REG    = T5_IN + DIV_LAT;
  localparam int T6_IN     = T6_REG + 1;
  localparam int MERGE     = T6_IN + DIV_LAT;
  localparam int OUT_LAT   = MERGE + 1;
  localparam int EXP_START = T6_IN - 2 - 3 * EXP_TERMS - LN_STEPS;
  localparam int C1_IN     = MERGE - (3 * DIV_LAT + 4);
  localparam int C2_IN     = C1_IN + DIV_LAT;
  localparam int C3_REG    = C2_IN + DIV_LAT;
  localparam int C3_IN     = C3_REG + 1;
  localparam int C4_REG    = C3_IN + DIV_LAT;
  localparam int C5        = C4_REG + 1;
  localparam int Y_LAST    = C3_REG;

  function automatic opnd_t qsub(input opnd_t a, input opnd_t b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

// ----- rtl/core/normal_cdf_unit.sv -----
// Normal CDF unit: fully pipelined, one request accepted per clock, busy is always low.
// done and cdf_value show the result of each accepted request; the pipeline
// depth is set by six chained 36-stage dividers on the upper-tail path.
// Reset (synchronous) clears only the valid pipeline and done; the receiver cannot stall.
// Depends on ncdf_pkg and ncdf_div.
module normal_cdf_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [ncdf_pkg::Z_W-1:0] z_value,
  output logic                          busy,
  output logic                          done,
  output logic [ncdf_pkg::OUT_W-1:0]    cdf_value
);
  import ncdf_pkg::*;

  typedef struct packed {
    logic             neg;
    logic             far;
    logic             cen;
    logic [MAG_W-1:0] mag;
  } side_t;

  function automatic opnd_t zq_of(input logic [MAG_W-1:0] m);
    return QW'({m, {ZQ_SH{1'b0}}});
  endfunction

  assign busy = 1'b0;

  // ---------------------------------------------------------------- input
  logic [Z_W-1:0]   z_raw;
  logic             z_neg;
  logic [MAG_W-1:0] z_mag;
  logic             z_far;
  logic             z_cen;

  assign z_raw = z_value;
  assign z_neg = z_raw[Z_W-1];
  assign z_mag = z_neg ? MAG_W'(~z_raw + 1'b1) : MAG_W'(z_raw);
  assign z_far = (LIM_W'(z_mag) * LIM_W'(FAR_DEN)) > FAR_LIM;
  assign z_cen = (LIM_W'(z_mag) * LIM_W'(CEN_DEN)) <= CEN_LIM;

  logic [MERGE:0] vld_q;
  side_t          side_q [0:MERGE];
  logic [YW-1:0]  y_q    [1:Y_LAST];
  logic [2*MAG_W-1:0] msq;

  assign msq = (2*MAG_W)'(side_q[0].mag) * (2*MAG_W)'(side_q[0].mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
      done  <= 1'b0;
    end else begin
      vld_q <= {vld_q[MERGE-1:0], start & ~busy};
      done  <= vld_q[MERGE];
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= '{neg: z_neg, far: z_far, cen: z_cen, mag: z_mag};
    for (int k = 1; k <= MERGE; k++) begin
      side_q[k] <= side_q[k-1];
    end
    y_q[1] <= YW'({msq, {Y_SH{1'b0}}});
    for (int k = 2; k <= Y_LAST; k++) begin
      y_q[k] <= y_q[k-1];
    end
  end

  // ---------------------------------------------------------------- exp(-y)
  logic [YW-1:0]       rr_q [1:LN_STEPS];
  logic [LN_STEPS-1:0] nn_q [1:LN_STEPS];

  for (genvar j = 0; j < LN_STEPS; j++) begin : g_red
    localparam logic [YW-1:0] STEP = YW'(LN2) << (LN_STEPS - 1 - j);
    logic [YW-1:0]       rr_in;
    logic [LN_STEPS-1:0] nn_in;
    logic                take;
    if (j == 0) begin : g_first
      assign rr_in = y_q[EXP_START];
      assign nn_in = '0;
    end else begin : g_next
      assign rr_in = rr_q[j];
      assign nn_in = nn_q[j];
    end
    assign take = rr_in >= STEP;
    always_ff @(posedge clk) begin
      rr_q[j+1] <= take ? rr_in - STEP : rr_in;
      nn_q[j+1] <= {nn_in[LN_STEPS-2:0], take};
    end
  end

  localparam int TERM_STAGES = 3 * EXP_TERMS;
  localparam int RX_LAST     = 3 * (EXP_TERMS - 1);

  logic [QFRAC-1:0]    rx_q [1:RX_LAST];
  logic [LN_STEPS-1:0] nx_q [1:TERM_STAGES];
  logic [QFRAC-1:0]    p_q  [0:EXP_TERMS-1];
  logic [QFRAC-1:0]    pb_q [0:EXP_TERMS-1];
  logic [QFRAC-1:0]    m_q  [0:EXP_TERMS-1];
  logic [QFRAC:0]      e_q  [1:EXP_TERMS];
  logic [QFRAC:0]      exp_q;
  logic [QFRAC-1:0]    pdf_q;

  always_ff @(posedge clk) begin
    rx_q[1] <= rr_q[LN_STEPS][QFRAC-1:0];
    for (int k = 2; k <= RX_LAST; k++) begin
      rx_q[k] <= rx_q[k-1];
    end
    nx_q[1] <= nn_q[LN_STEPS];
    for (int k = 2; k <= TERM_STAGES; k++) begin
      nx_q[k] <= nx_q[k-1];
    end
  end

  // Each term: e = 1 - floor(r*e)/k, as multiply, reciprocal multiply, correct.
  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
    localparam int KDIV = EXP_TERMS - i;
    localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'((64'd1 << RECIP_SH) / KDIV);
    logic [QFRAC-1:0] r_in;
    logic [QFRAC:0]   e_in;
    logic [35:0]      mk;
    logic [35:0]      rem;
    logic [QFRAC:0]   fix;
    if (i == 0) begin : g_first
      assign r_in = rr_q[LN_STEPS][QFRAC-1:0];
      assign e_in = QONE;
    end else begin : g_next
      assign r_in = rx_q[3*i];
      assign e_in = e_q[i];
    end
    assign mk  = 36'(m_q[i]) * 36'(KDIV);
    assign rem = 36'(pb_q[i]) - mk;
    assign fix = (QFRAC+1)'(m_q[i]) + (QFRAC+1)'(rem >= 36'(KDIV));
    always_ff @(posedge clk) begin
      p_q[i]    <= QFRAC'((65'(r_in) * 65'(e_in)) >> QFRAC);
      pb_q[i]   <= p_q[i];
      m_q[i]    <= QFRAC'((69'(p_q[i]) * 69'(RECIP)) >> RECIP_SH);
      e_q[i+1]  <= QONE - fix;
    end
  end

  always_ff @(posedge clk) begin
    exp_q <= nx_q[TERM_STAGES][LN_STEPS-1] ? '0 :
             e_q[EXP_TERMS] >> nx_q[TERM_STAGES][LN_STEPS-2:0];
    pdf_q <= QFRAC'((65'(K_T12) * 65'(exp_q)) >> QFRAC);
  end

  // ---------------------------------------------------------------- upper tail
  quot_t t1, t2, t3, d1, d2, qt;
  opnd_t s3_q, s4_q, s6_q;

  ncdf_div u_t1 (.clk, .num(K_T1), .den(QW'(zq_of(side_q[T1_IN].mag) + K_T2)), .quo(t1));
  ncdf_div u_t2 (.clk, .num(K_T4),
                 .den(QW'(zq_of(side_q[T2_IN].mag) + K_T3 + QW'(t1))), .quo(t2));
  ncdf_div u_t3 (.clk, .num(K_T6), .den(s3_q), .quo(t3));
  ncdf_div u_t4 (.clk, .num(K_T8), .den(s4_q), .quo(d1));
  ncdf_div u_t5 (.clk, .num(K_T10),
                 .den(QW'(zq_of(side_q[T5_IN].mag) + K_T9 + QW'(d1))), .quo(d2));
  ncdf_div u_t6 (.clk, .num(QW'(pdf_q)), .den(s6_q), .quo(qt));

  always_ff @(posedge clk) begin
    s3_q <= qsub(QW'(zq_of(side_q[T3_REG].mag) + K_T5), QW'(t2));
    s4_q <= QW'(qsub(zq_of(side_q[T4_REG].mag), K_T7) + QW'(t3));
    s6_q <= QW'(qsub(zq_of(side_q[T6_REG].mag), K_T11) + QW'(d2));
  end

  // ---------------------------------------------------------------- central band
  quot_t          c1, c2, uc;
  opnd_t          t3c_q;
  logic [QFRAC-1:0] mc_q;
  logic [QFRAC-1:0] u2_q;
  logic [QFRAC:0]   u3_q;
  logic [QFRAC:0]   qc_q;
  opnd_t          zq_c5;

  assign zq_c5 = zq_of(side_q[C5].mag);

  ncdf_div u_c1 (.clk, .num(K_CA), .den(QW'(y_q[C1_IN] + YW'(K_CB))), .quo(c1));
  ncdf_div u_c2 (.clk, .num(K_CD),
                 .den(QW'(y_q[C2_IN] + YW'(K_CC) + YW'(c1))), .quo(c2));
  ncdf_div u_c3 (.clk, .num(QW'(mc_q)), .den(t3c_q), .quo(uc));

  always_ff @(posedge clk) begin
    t3c_q <= qsub(QW'(y_q[C3_REG] + YW'(K_CE)), QW'(c2));
    mc_q  <= QFRAC'((64'(K_CF) * 64'(y_q[C3_REG][QFRAC-1:0])) >> QFRAC);
    u2_q  <= QFRAC'(qsub(QW'(K_CG), QW'(uc)));
    u3_q  <= (QFRAC+1)'((65'(zq_c5[QFRAC:0]) * 65'(u2_q)) >> QFRAC);
    qc_q  <= (u3_q < QHALF) ? QHALF - u3_q : '0;
  end

  // ---------------------------------------------------------------- merge and round
  side_t              sm;
  logic [QFRAC:0]     q_sel;
  logic [QFRAC:0]     v_sel;
  logic [QFRAC+1:0]   v_rnd;
  logic [OUT_W-1:0]   cdf_next;

  assign sm    = side_q[MERGE];
  assign q_sel = sm.far ? '0 : (sm.cen ? qc_q : qt[QFRAC:0]);
  assign v_sel = sm.neg ? q_sel : ((q_sel < QONE) ? QONE - q_sel : '0);
  assign v_rnd = ((QFRAC+2)'(v_sel) + RND_HALF) >> RND_SH;
  assign cdf_next = (v_rnd > (QFRAC+2)'(OUT_ONE)) ? OUT_ONE : OUT_W'(v_rnd);

  always_ff @(posedge clk) begin
    cdf_value <= cdf_next;
  end

  // ---------------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(OUT_LAT + 1) done)
    else $error("accepted request produced no result at the pipeline depth");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, OUT_LAT + 1))
    else $error("result without a matching request");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cdf_value <= OUT_ONE))
    else $error("cdf result above 1.0");

endmodule

// ----- rtl/core/ncdf_div.sv -----
// Pipelined restoring divider: quo = floor(num * 2^32 / den), one quotient bit per stage.
// Depends on ncdf_pkg; valid bits travel outside, alongside this pipeline.
module ncdf_div (
  input  logic          clk,
  input  ncdf_pkg::opnd_t num,
  input  ncdf_pkg::opnd_t den,
  output ncdf_pkg::quot_t quo
);
  import ncdf_pkg::*;

  opnd_t rem_q  [0:QB];
  quot_t bits_q [0:QB];
  opnd_t den_q  [0:QB-1];

  // Upper part of num starts as the partial remainder; the rest shifts in bit by bit.
  always_ff @(posedge clk) begin
    rem_q[0]  <= num >> (QB - QFRAC);
    bits_q[0] <= QB'({num, {QFRAC{1'b0}}});
    den_q[0]  <= den;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [QW:0] trial;
    logic        ge;
    assign trial = {rem_q[s], bits_q[s][QB-1]};
    assign ge    = trial >= {1'b0, den_q[s]};
    always_ff @(posedge clk) begin
      rem_q[s+1]  <= ge ? QW'(trial - {1'b0, den_q[s]}) : trial[QW-1:0];
      bits_q[s+1] <= {bits_q[s][QB-2:0], ge};
    end
    if (s < QB - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign quo = bits_q[QB];

endmodule
